@@ rtl/ptfi_pkg.sv @@
// shared types and constants for the plane table find-or-insert core
package ptfi_pkg;

  localparam int unsigned DefaultDepth = 512;
  localparam int unsigned IndexWidth   = 9;
  localparam int unsigned KeyWidth     = 109;
  localparam int unsigned EntryWidth   = KeyWidth + 16;
  localparam int unsigned InDataWidth  = 128;
  localparam int unsigned OutDataWidth = 16;
  localparam int unsigned CfgIdxWidth  = 1;
  localparam int unsigned CfgDataWidth = 28;

  localparam logic CMD_FIND  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [CfgIdxWidth-1:0] REG_SKY_PICTURE      = 1'd0;
  localparam logic [CfgIdxWidth-1:0] REG_DEFAULT_COLORMAP = 1'd1;

  // key fields after sky substitution
  typedef struct packed {
    logic [31:0] height;
    logic [27:0] picture;
    logic [7:0]  light;
    logic [15:0] colormap;
    logic [15:0] fog;
    logic        is_3d;
    logic [7:0]  style;
  } key_t;

  // item handed from front to back
  typedef struct packed {
    logic        clear;
    key_t        key;
    logic [15:0] render_table;
  } item_t;

  typedef struct packed {
    logic [IndexWidth-1:0] plane_index;
    logic                  inserted;
    logic                  table_full;
  } result_t;

endpackage

@@ rtl/plane_table_find_or_insert_core.sv @@
// top level of the plane table find-or-insert core
//
// A find beat walks the filled entries of the entry memory one at a time (read,
// compare) and stops at the first match; if none matches and the table is not
// full, a new plane is appended in the final state (S_DONE). A clear beat goes
// straight to S_DONE. The back end handles one beat at a time and starts the next
// only once the result register is empty. A two-beat queue lets input beats arrive
// while a search runs, and the result register holds one beat for the consumer.
module plane_table_find_or_insert_core import ptfi_pkg::*; #(
  parameter int unsigned TableDepth = DefaultDepth
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // plane_height, picture, light_level, colormap_id, fog_id, is_3d,
  // render_style, render_table_id, zero fill
  input  logic [InDataWidth-1:0]  s_tdata,
  // cmd
  input  logic                    s_tuser,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // plane_index, inserted, table_full, zero fill
  output logic [OutDataWidth-1:0] m_tdata
);

  logic    q_valid, q_pop, busy;
  item_t   q_item;
  result_t res;

  ptfi_front #(.QueueDepth(2)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .in_user   (s_tuser),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  ptfi_back #(.TableDepth(TableDepth)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (res),
    .busy       (busy)
  );

  assign m_tdata = {{(OutDataWidth-IndexWidth-2){1'b0}},
                    res.table_full, res.inserted, res.plane_index};

  a_pop_only_busy: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> busy && q_valid)
    else $error("queue popped while back end idle or queue empty");

  a_result_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(res.inserted && res.table_full))
    else $error("result both inserted and full");

  a_full_index_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.table_full |-> res.plane_index == '0)
    else $error("full result with nonzero index");

  a_result_after_pop: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> m_tvalid)
    else $error("no result after item retired");

endmodule

@@ rtl/ptfi_ram.sv @@
// generic ram with one write port and one registered read port
module ptfi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/ptfi_front.sv @@
// input stage: unpacks a beat, applies sky substitution, feeds the queue
module ptfi_front import ptfi_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [InDataWidth-1:0]  in_data,
  input  logic                    in_user,
  output logic                    q_valid,
  input  logic                    q_pop,
  output item_t                   q_item
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  logic [27:0] sky_picture;
  logic [15:0] default_colormap;
  item_t       slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [PtrW:0]   fill;
  item_t       item;
  logic        push;

  always_ff @(posedge clk) begin
    if (rst) begin
      sky_picture      <= '0;
      default_colormap <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SKY_PICTURE:      sky_picture      <= cfg_data[27:0];
        REG_DEFAULT_COLORMAP: default_colormap <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    item.clear           = in_user;
    item.key.height      = in_data[31:0];
    item.key.picture     = in_data[59:32];
    item.key.light       = in_data[67:60];
    item.key.colormap    = in_data[83:68];
    item.key.fog         = in_data[99:84];
    item.key.is_3d       = in_data[100];
    item.key.style       = in_data[108:101];
    item.render_table    = in_data[124:109];
    if (in_data[59:32] == sky_picture) begin
      item.key.height   = '0;
      item.key.light    = '0;
      item.key.colormap = default_colormap;
    end
  end

  assign in_ready = (fill != (PtrW+1)'(QueueDepth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != '0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth-1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
    end
  end

endmodule

@@ rtl/ptfi_back.sv @@
// search and append engine over the entry memory, with output register
module ptfi_back import ptfi_pkg::*; #(
  parameter int unsigned TableDepth = DefaultDepth
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  output logic    q_pop,
  input  item_t   q_item,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result,
  output logic    busy
);

  localparam int unsigned AddrW  = $clog2(TableDepth);
  localparam int unsigned CountW = $clog2(TableDepth + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_CMP   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [CountW-1:0] used_count;
  logic [CountW-1:0] scan;
  logic [AddrW-1:0]  raddr;
  logic [EntryWidth-1:0] rdata, wdata;
  logic              we;
  logic              hit;
  logic              found;
  logic [CountW-1:0] found_idx;

  assign raddr = scan[AddrW-1:0];
  assign wdata = {q_item.key, q_item.render_table};
  assign hit   = (rdata[EntryWidth-1:16] == q_item.key);
  assign busy  = (state != S_IDLE);

  ptfi_ram #(.Width(EntryWidth), .Depth(TableDepth)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (used_count[AddrW-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    we         = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid && !out_valid) begin
          if (q_item.clear || scan == used_count) begin
            state_next = S_DONE;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ: state_next = S_CMP;
      S_CMP: begin
        if (hit || scan + 1'b1 == used_count) begin
          state_next = S_DONE;
        end else begin
          state_next = S_READ;
        end
      end
      S_DONE: begin
        q_pop      = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (state == S_DONE && !q_item.clear && !found &&
        used_count != CountW'(TableDepth)) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      scan       <= '0;
      found      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          scan  <= '0;
          found <= 1'b0;
        end
        S_READ: ;
        S_CMP: begin
          if (hit) begin
            found     <= 1'b1;
            found_idx <= scan;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          if (q_item.clear) begin
            used_count <= '0;
            out_result <= '{plane_index: '0, inserted: 1'b0, table_full: 1'b0};
          end else if (found) begin
            out_result <= '{plane_index: IndexWidth'(found_idx),
                            inserted: 1'b0, table_full: 1'b0};
          end else if (used_count == CountW'(TableDepth)) begin
            out_result <= '{plane_index: '0, inserted: 1'b0, table_full: 1'b1};
          end else begin
            used_count <= used_count + 1'b1;
            out_result <= '{plane_index: IndexWidth'(used_count),
                            inserted: 1'b1, table_full: 1'b0};
          end
        end
        default: ;
      endcase
    end
  end

endmodule
